FILE: rtl/utf8v_pkg.sv
// utf8v_pkg: item, verdict and sequence-state types for the UTF-8 stream validator.
// Also holds the lead-byte bounds and error codes. Depends on nothing.
package utf8v_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_string;
  } byte_item_t;

  typedef struct packed {
    logic        string_valid;
    logic [1:0]  error_kind;
    logic [15:0] error_offset;
  } verdict_t;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_INVALID   = 2'd1;
  localparam logic [1:0] ERR_TRUNCATED = 2'd2;

  // Lead-byte class boundaries and second-byte limits
  localparam logic [7:0] LEAD_ASCII_END = 8'h80;
  localparam logic [7:0] LEAD_2B_MIN    = 8'hC2;
  localparam logic [7:0] LEAD_3B_FIRST  = 8'hE0;
  localparam logic [7:0] LEAD_SURR      = 8'hED;
  localparam logic [7:0] LEAD_4B_FIRST  = 8'hF0;
  localparam logic [7:0] LEAD_4B_LAST   = 8'hF4;
  localparam logic [7:0] SECOND_A0      = 8'hA0;
  localparam logic [7:0] SECOND_90      = 8'h90;
  localparam logic [7:0] CONT_MASK      = 8'hC0;
  localparam logic [7:0] CONT_TAG       = 8'h80;

  typedef struct packed {
    logic [1:0]  bytes_still_expected;
    logic [7:0]  sequence_lead;
    logic [1:0]  position_in_sequence;
    logic        sequence_has_fault;
    logic        error_seen;
    logic [1:0]  seen_error_kind;
    logic [15:0] running_offset;
    logic [15:0] lead_offset;
    logic [15:0] seen_error_offset;
  } seq_state_t;

endpackage

FILE: rtl/utf8v_step.sv
// utf8v_step: next-state and verdict logic for one item of the stream.
// Depends on utf8v_pkg.
module utf8v_step #(
  parameter logic [15:0] OffsetCap = 16'hFFFF
) (
  input  utf8v_pkg::seq_state_t st,
  input  utf8v_pkg::byte_item_t item,
  output utf8v_pkg::seq_state_t st_next,
  output logic                  emit,
  output utf8v_pkg::verdict_t   result
);
  import utf8v_pkg::*;

  function automatic logic is_cont(input logic [7:0] b);
    return (b & CONT_MASK) == CONT_TAG;
  endfunction

  function automatic logic second_bad(input logic [7:0] lead, input logic [7:0] b);
    logic bad;
    bad = !is_cont(b);
    if (lead == LEAD_3B_FIRST && b < SECOND_A0) bad = 1'b1;
    if (lead == LEAD_SURR && b >= SECOND_A0) bad = 1'b1;
    if (lead == LEAD_4B_FIRST && b < SECOND_90) bad = 1'b1;
    if (lead == LEAD_4B_LAST && b >= SECOND_90) bad = 1'b1;
    return bad;
  endfunction

  seq_state_t s;
  logic [7:0] b;

  always_comb begin
    s      = st;
    b      = item.data_byte;
    emit   = item.end_of_string;
    result = '0;

    if (item.byte_present) begin
      if (!s.error_seen) begin
        if (s.bytes_still_expected == 2'd0) begin
          // open a new sequence at this lead
          s.sequence_lead        = b;
          s.lead_offset          = s.running_offset;
          s.position_in_sequence = 2'd1;
          s.sequence_has_fault   = 1'b0;
          if (b < LEAD_ASCII_END) begin
            s.position_in_sequence = 2'd0;
          end else if (b < LEAD_3B_FIRST) begin
            s.bytes_still_expected = 2'd1;
            s.sequence_has_fault   = (b < LEAD_2B_MIN);
          end else if (b < LEAD_4B_FIRST) begin
            s.bytes_still_expected = 2'd2;
          end else begin
            s.bytes_still_expected = 2'd3;
            s.sequence_has_fault   = (b > LEAD_4B_LAST);
          end
        end else begin
          if (s.position_in_sequence == 2'd1) begin
            if (second_bad(s.sequence_lead, b)) s.sequence_has_fault = 1'b1;
          end else if (!is_cont(b)) begin
            s.sequence_has_fault = 1'b1;
          end
          s.position_in_sequence = s.position_in_sequence + 2'd1;
          s.bytes_still_expected = s.bytes_still_expected - 2'd1;
          if (s.bytes_still_expected == 2'd0) begin
            s.position_in_sequence = 2'd0;
            if (s.sequence_has_fault) begin
              s.error_seen        = 1'b1;
              s.seen_error_kind   = ERR_INVALID;
              s.seen_error_offset = s.lead_offset;
            end
            s.sequence_has_fault = 1'b0;
          end
        end
      end
      if (s.running_offset < OffsetCap) s.running_offset = s.running_offset + 16'd1;
    end

    if (item.end_of_string) begin
      // a sequence cut off by the end counts as truncated
      if (!s.error_seen && s.bytes_still_expected != 2'd0) begin
        s.error_seen        = 1'b1;
        s.seen_error_kind   = ERR_TRUNCATED;
        s.seen_error_offset = s.lead_offset;
      end
      result.string_valid = !s.error_seen;
      result.error_kind   = s.error_seen ? s.seen_error_kind : ERR_NONE;
      result.error_offset = s.error_seen ? s.seen_error_offset : 16'd0;
      s = '0;
    end

    st_next = s;
  end

endmodule

FILE: rtl/utf8_stream_validator_core.sv
// utf8_stream_validator_core: top level of the UTF-8 stream validator.
// Depends on utf8v_pkg and utf8v_step.
//
//  channel  | handshake                  | payload   | items
//  ---------+----------------------------+-----------+------------------------------
//  input    | byte_valid / byte_ready    | byte_item | one byte or bare end marker
//  output   | verdict_valid / verdict_ready | verdict | one verdict per end_of_string
//
// Flow: one item per cycle while the result register is empty or being taken; an
//   item waits in the input register, and an end item's verdict is registered as it advances.
// The per-string sequence state is computed combinationally from the held item
//   and committed only when that item advances.
// Reset: rst (synchronous) clears both stages' valid flags and all sequence state.
// Stalls: while a verdict waits, the held item stays put; the input register
//   still takes a new item whenever it is empty.
module utf8_stream_validator_core #(
  parameter int MAX_STRING_BYTES = 65536
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  byte_valid,
  output logic                  byte_ready,
  input  utf8v_pkg::byte_item_t byte_item,
  output logic                  verdict_valid,
  input  logic                  verdict_ready,
  output utf8v_pkg::verdict_t   verdict
);
  import utf8v_pkg::*;

  // Offsets saturate at the lesser of MAX_STRING_BYTES - 1 and 65535
  localparam logic [15:0] OFFSET_CAP =
    (MAX_STRING_BYTES - 1 > 65535) ? 16'hFFFF : 16'(MAX_STRING_BYTES - 1);

  byte_item_t hold;
  logic       hold_valid;
  seq_state_t st;
  seq_state_t st_next;
  logic       emit;
  verdict_t   result;
  logic       out_free;
  logic       advance;

  // The result register frees up this cycle if empty or being taken
  assign out_free   = !verdict_valid || verdict_ready;
  // Advance the held item into the state when its verdict has a place to go
  assign advance    = hold_valid && out_free;
  assign byte_ready = !hold_valid || out_free;

  utf8v_step #(
    .OffsetCap(OFFSET_CAP)
  ) u_step (
    .st     (st),
    .item   (hold),
    .st_next(st_next),
    .emit   (emit),
    .result (result)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (byte_valid && byte_ready) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
    if (byte_valid && byte_ready) hold <= byte_item;
  end

  // Sequence state: commit only when the held item advances
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // Result register: load the verdict of an end item, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      verdict_valid <= 1'b0;
    end else if (advance && emit) begin
      verdict_valid <= 1'b1;
    end else if (verdict_ready) begin
      verdict_valid <= 1'b0;
    end
    if (advance && emit) verdict <= result;
  end

`ifndef ASSERT_OFF
  // A verdict is only loaded from an item that ended a string
  a_verdict_from_end: assert property (@(posedge clk) disable iff (rst)
    (advance && !hold.end_of_string) |=> !(verdict_valid && !$past(verdict_valid)))
    else $error("verdict loaded from an item without end_of_string");

  // Valid flag and error code agree
  a_valid_kind: assert property (@(posedge clk) disable iff (rst)
    verdict_valid |-> (verdict.string_valid == (verdict.error_kind == ERR_NONE)))
    else $error("string_valid disagrees with error_kind");

  // No open sequence means no partial position and no pending fault
  a_idle_seq: assert property (@(posedge clk) disable iff (rst)
    (st.bytes_still_expected == 2'd0) |->
      (st.position_in_sequence == 2'd0 && !st.sequence_has_fault))
    else $error("sequence state left dangling");

  // A latched error always carries a kind
  a_latched_kind: assert property (@(posedge clk) disable iff (rst)
    st.error_seen |-> (st.seen_error_kind != ERR_NONE))
    else $error("error latched without a kind");

  // Back-pressure on the input only while an item is held
  a_ready_hold: assert property (@(posedge clk) disable iff (rst)
    !byte_ready |-> hold_valid)
    else $error("input stalled with an empty input register");
`endif

endmodule

FILE: dv/tb_top.sv
// tb_top: self-checking bench for utf8_stream_validator_core.
// Holds a verdict predictor/scoreboard class and the byte and verdict drivers.
// Depends on utf8v_pkg and the RTL top level only.
`timescale 1ns / 1ps

module tb_top;
  import utf8v_pkg::*;

  localparam int MAX_BYTES  = 65536;
  // Offsets saturate at the lesser of MAX_BYTES - 1 and the 16-bit ceiling
  localparam int OFFSET_CAP = (MAX_BYTES - 1 > 65535) ? 65535 : MAX_BYTES - 1;
  // Cycles with no handshake on either channel before the run is declared hung
  localparam int STALL_LIMIT = 5000;
  // Minimum number of counted items sent per idling phase in the random part
  localparam int PHASE_ITEMS = 230;
  // Minimum length of the prefix before the failing lead in the directed long string
  localparam int LONG_BYTES = 96;

  logic       clk;
  logic       rst;
  logic       byte_valid;
  logic       byte_ready;
  byte_item_t byte_item;
  logic       verdict_valid;
  logic       verdict_ready;
  verdict_t   verdict;

  int send_idle_pct;
  int recv_stall_pct;
  int counted_items;
  int quiet_cycles;

  // String under construction, one byte per entry
  logic [7:0] byte_q[$];

  // Predicts one verdict per string from the accepted items and checks the
  // verdicts leaving the block against them in order.
  class utf8_verdict_book;
    seq_state_t st;
    verdict_t   expected_verdicts[$];
    int         mismatches;

    function new();
      clear_string();
      mismatches = 0;
    endfunction

    function void clear_string();
      st = '0;
    endfunction

    function bit is_cont(logic [7:0] b);
      return (b & CONT_MASK) == CONT_TAG;
    endfunction

    // Range checks on the second byte depend on the lead byte
    function bit second_bad(logic [7:0] lead, logic [7:0] b);
      if (!is_cont(b)) return 1'b1;
      if (lead == LEAD_3B_FIRST && b < SECOND_A0) return 1'b1;
      if (lead == LEAD_SURR && b >= SECOND_A0) return 1'b1;
      if (lead == LEAD_4B_FIRST && b < SECOND_90) return 1'b1;
      if (lead == LEAD_4B_LAST && b >= SECOND_90) return 1'b1;
      return 1'b0;
    endfunction

    function void latch_error(logic [1:0] kind, logic [15:0] off);
      st.error_seen        = 1'b1;
      st.seen_error_kind   = kind;
      st.seen_error_offset = off;
    endfunction

    function void note_item(byte_item_t it);
      logic [7:0] b;
      verdict_t   v;
      b = it.data_byte;
      if (it.byte_present) begin
        if (!st.error_seen) begin
          if (st.bytes_still_expected == 2'd0) begin
            st.sequence_lead        = b;
            st.lead_offset          = st.running_offset;
            st.position_in_sequence = 2'd1;
            st.sequence_has_fault   = 1'b0;
            if (b < LEAD_ASCII_END) begin
              st.position_in_sequence = 2'd0;
            end else if (b < LEAD_3B_FIRST) begin
              // stray continuations and C0/C1 act as faulty 2-byte leads
              st.bytes_still_expected = 2'd1;
              st.sequence_has_fault   = (b < LEAD_2B_MIN);
            end else if (b < LEAD_4B_FIRST) begin
              st.bytes_still_expected = 2'd2;
            end else begin
              st.bytes_still_expected = 2'd3;
              st.sequence_has_fault   = (b > LEAD_4B_LAST);
            end
          end else begin
            if (st.position_in_sequence == 2'd1) begin
              if (second_bad(st.sequence_lead, b)) st.sequence_has_fault = 1'b1;
            end else if (!is_cont(b)) begin
              st.sequence_has_fault = 1'b1;
            end
            st.position_in_sequence = st.position_in_sequence + 2'd1;
            st.bytes_still_expected = st.bytes_still_expected - 2'd1;
            if (st.bytes_still_expected == 2'd0) begin
              st.position_in_sequence = 2'd0;
              if (st.sequence_has_fault) latch_error(ERR_INVALID, st.lead_offset);
              st.sequence_has_fault = 1'b0;
            end
          end
        end
        if (st.running_offset < OFFSET_CAP) st.running_offset = st.running_offset + 16'd1;
      end
      if (!it.end_of_string) return;
      // A cut-off sequence reports truncation whatever its bytes held
      if (!st.error_seen && st.bytes_still_expected != 2'd0)
        latch_error(ERR_TRUNCATED, st.lead_offset);
      v.string_valid = !st.error_seen;
      v.error_kind   = st.error_seen ? st.seen_error_kind : ERR_NONE;
      v.error_offset = st.error_seen ? st.seen_error_offset : 16'd0;
      expected_verdicts.push_back(v);
      clear_string();
    endfunction

    task report_mismatch(string what, int unsigned got, int unsigned want);
      mismatches++;
      $display("[%0t] MISMATCH %s: got %0h, want %0h", $time, what, got, want);
    endtask

    task check_verdict(verdict_t got);
      verdict_t want;
      if (expected_verdicts.size() == 0) begin
        report_mismatch("unexpected verdict", got, 0);
        return;
      end
      want = expected_verdicts.pop_front();
      if (got.string_valid !== want.string_valid)
        report_mismatch("string_valid", got.string_valid, want.string_valid);
      if (got.error_kind !== want.error_kind)
        report_mismatch("error_kind", got.error_kind, want.error_kind);
      if (got.error_offset !== want.error_offset)
        report_mismatch("error_offset", got.error_offset, want.error_offset);
    endtask

    function int pending();
      return expected_verdicts.size();
    endfunction
  endclass

  utf8_verdict_book book = new();

  utf8_stream_validator_core #(.MAX_STRING_BYTES(MAX_BYTES)) dut (
    .clk           (clk),
    .rst           (rst),
    .byte_valid    (byte_valid),
    .byte_ready    (byte_ready),
    .byte_item     (byte_item),
    .verdict_valid (verdict_valid),
    .verdict_ready (verdict_ready),
    .verdict       (verdict)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver: decide ready at the falling edge, take verdicts at the rising one.
  always @(negedge clk) begin
    if (rst) begin
      verdict_ready <= 1'b0;
    end else begin
      verdict_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && verdict_valid && verdict_ready) book.check_verdict(verdict);
  end

  // Watchdog: any handshake resets the count; a long silence means a hang.
  always @(posedge clk) begin
    if (rst || (byte_valid && byte_ready) || (verdict_valid && verdict_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic byte_item_t make_item(logic [7:0] b, logic present, logic last);
    byte_item_t it;
    it.data_byte     = b;
    it.byte_present  = present;
    it.end_of_string = last;
    return it;
  endfunction

  // Present one item and hold it until accepted; idle first at the phase's rate.
  task automatic send_item(byte_item_t it);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      byte_valid <= 1'b0;
      byte_item  <= make_item(8'($urandom_range(255)), 1'($urandom_range(1)),
                              1'($urandom_range(1)));
      @(negedge clk);
    end
    byte_valid <= 1'b1;
    byte_item  <= it;
    do @(posedge clk); while (!byte_ready);
    book.note_item(it);
    // bare items without an end mark are ignored by the block; skip them
    if (it.byte_present || it.end_of_string) counted_items++;
  endtask

  // Send byte_q as one string; end it on the last byte or with a bare end mark.
  task automatic send_string(bit bare_end);
    int n;
    n = byte_q.size();
    for (int i = 0; i < n; i++)
      send_item(make_item(byte_q[i], 1'b1, !bare_end && (i == n - 1)));
    if (bare_end || n == 0) send_item(make_item(8'($urandom_range(255)), 1'b0, 1'b1));
  endtask

  function automatic logic [7:0] cont_byte(int lo, int hi);
    return 8'($urandom_range(hi, lo));
  endfunction

  // Append one well-formed code point, leaning on the boundary leads.
  task automatic append_code_point();
    logic [7:0] lead;
    case ($urandom_range(3))
      0: byte_q.push_back(8'($urandom_range(8'h7F)));
      1: begin
        byte_q.push_back(8'($urandom_range(8'hDF, 8'hC2)));
        byte_q.push_back(cont_byte(8'h80, 8'hBF));
      end
      2: begin
        lead = ($urandom_range(2) == 0) ? ($urandom_range(1) ? LEAD_3B_FIRST : LEAD_SURR)
                                        : 8'($urandom_range(8'hEF, 8'hE0));
        byte_q.push_back(lead);
        if (lead == LEAD_3B_FIRST) byte_q.push_back(cont_byte(8'hA0, 8'hBF));
        else if (lead == LEAD_SURR) byte_q.push_back(cont_byte(8'h80, 8'h9F));
        else byte_q.push_back(cont_byte(8'h80, 8'hBF));
        byte_q.push_back(cont_byte(8'h80, 8'hBF));
      end
      default: begin
        lead = ($urandom_range(1) == 0) ? ($urandom_range(1) ? LEAD_4B_FIRST : LEAD_4B_LAST)
                                        : 8'($urandom_range(8'hF4, 8'hF0));
        byte_q.push_back(lead);
        if (lead == LEAD_4B_FIRST) byte_q.push_back(cont_byte(8'h90, 8'hBF));
        else if (lead == LEAD_4B_LAST) byte_q.push_back(cont_byte(8'h80, 8'h8F));
        else byte_q.push_back(cont_byte(8'h80, 8'hBF));
        byte_q.push_back(cont_byte(8'h80, 8'hBF));
        byte_q.push_back(cont_byte(8'h80, 8'hBF));
      end
    endcase
  endtask

  // Mostly well-formed strings; about a third get one defect.
  task automatic build_random_string();
    int cps;
    byte_q.delete();
    cps = $urandom_range(10);
    repeat (cps) append_code_point();
    if ($urandom_range(99) < 35) begin
      case ($urandom_range(3))
        0: if (byte_q.size() > 0)
             byte_q[$urandom_range(byte_q.size() - 1)] = 8'($urandom_range(255));
        1: repeat ($urandom_range(2, 1)) if (byte_q.size() > 0) byte_q.pop_back();
        2: byte_q.insert($urandom_range(byte_q.size()), 8'($urandom_range(255)));
        default: byte_q.push_back(8'($urandom_range(8'hFF, 8'h80)));
      endcase
    end
  endtask

  initial begin
    int phase_idle[4];
    int phase_stall[4];
    int phase_start;
    rst            = 1'b1;
    byte_valid     = 1'b0;
    byte_item      = '0;
    verdict_ready  = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    counted_items  = 0;
    quiet_cycles   = 0;
    phase_idle     = '{0, 58, 0, 26};
    phase_stall    = '{0, 0, 58, 26};
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty string via bare end mark
    byte_q = {};
    send_string(1'b0);
    // bare item with no end mark does nothing, then a one-byte string
    send_item(make_item(8'hA5, 1'b0, 1'b0));
    byte_q = '{8'h41};
    send_string(1'b0);
    // ASCII extremes, the second closed by a bare end mark
    byte_q = '{8'h00};
    send_string(1'b0);
    byte_q = '{8'h7F};
    send_string(1'b1);
    // stray continuation cut off by the end: truncated
    byte_q = '{8'h80};
    send_string(1'b0);
    // overlong C1 lead with its second byte: invalid
    byte_q = '{8'hC1, 8'h80};
    send_string(1'b0);
    // out-of-range lead cut off: truncated, not invalid
    byte_q = '{8'hFF};
    send_string(1'b0);
    // overlong 3-byte form cut off: the fault hides behind truncation
    byte_q = '{8'hE0, 8'h9F};
    send_string(1'b0);
    // highest code point: valid
    byte_q = '{8'hF4, 8'h8F, 8'hBF, 8'hBF};
    send_string(1'b0);
    // surrogate after one ASCII byte: invalid at offset 1
    byte_q = '{8'h41, 8'hED, 8'hA0, 8'h80};
    send_string(1'b0);
    // bad continuation latches; bytes after it are ignored
    byte_q = '{8'hC2, 8'h41, 8'hFF};
    send_string(1'b0);

    // One longer string so the failing lead sits at a large offset
    byte_q.delete();
    while (byte_q.size() < LONG_BYTES) append_code_point();
    byte_q.push_back(8'hC2);
    byte_q.push_back(8'h41);
    send_string(1'b0);

    // Random strings under each idling mix
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = phase_idle[p];
      recv_stall_pct = phase_stall[p];
      phase_start    = counted_items;
      while (counted_items - phase_start < PHASE_ITEMS) begin
        if ($urandom_range(99) < 5)
          send_item(make_item(8'($urandom_range(255)), 1'b0, 1'b0));
        build_random_string();
        send_string($urandom_range(5) == 0);
      end
    end

    @(negedge clk);
    byte_valid <= 1'b0;

    // Drain: wait for every verdict, then a few cycles for anything stray
    while (book.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (book.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/utf8v_pkg.sv
rtl/utf8v_step.sv
rtl/utf8_stream_validator_core.sv
dv/tb_top.sv
